/* hdl/twa_pkg.sv */
// twa_pkg: shared types and constants for the time and count window average block
// no dependencies; used by the top level by scoped names

package twa_pkg;

	// configuration port layout
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int WINDOW_W    = 32;
	localparam int NOMINAL_W   = 7;

	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_DURATION = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NOMINAL_COUNT   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MINIMUM_COUNT   = 2'd2;

	localparam logic [NOMINAL_W-1:0] NOMINAL_RESET = 7'd64;
	localparam logic [NOMINAL_W-1:0] MINIMUM_RESET = 7'd1;

	// request sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EVICT_CNT,
		ST_EVICT_AGE,
		ST_ADMIT,
		ST_DIV,
		ST_DONE
	} twa_state_t;

endpackage

/* hdl/twa_div.sv */
// twa_div: bit-serial restoring divider, signed dividend by unsigned divisor
// quotient truncated toward zero; one quotient bit per cycle; no package use

module twa_div #(
	parameter int NUM_W = 38,
	parameter int DEN_W = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic signed [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] work_q;
	logic             neg_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// shift the next dividend bit into the partial remainder
	assign trial = {rem_q, work_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend magnitude shifts out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
			neg_q  <= num[NUM_W-1];
			den_q  <= den;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			work_q <= {work_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed(work_q) : $signed(work_q);

endmodule

/* hdl/time_and_count_window_average.sv */
// Time and count window average. Each accepted request (timestamp, Q16.16 value) is stored in a
// ring memory of MAX_WINDOW entries; once nominal_count samples have arrived the block keeps a
// running sum over those of the last nominal_count samples not older than the timestamp minus
// window_duration (start clamped at zero), and publishes sum / count truncated toward zero when
// at least minimum_count samples (and at least one) are in the average, else it holds the last
// average with ready_res low. One request is in work at a time. A request walks the ring entries
// beyond the nominal count, the aged tail, and the samples that arrived since the last evaluation,
// then runs the bit-serial divider when an average is published. Every walked entry costs one read
// of the single ring memory. The next request is taken while the previous result still waits in the
// output register. Depends on twa_pkg and twa_div.

module time_and_count_window_average #(
	parameter int MAX_WINDOW  = 64,
	parameter int VALUE_WIDTH = 32,
	parameter int TIME_WIDTH  = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [twa_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [twa_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  logic [TIME_WIDTH-1:0]                 sample_time,
	input  logic signed [VALUE_WIDTH-1:0]         sample_value,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic                                  ready_res,
	output logic signed [VALUE_WIDTH-1:0]         average,
	output logic [$clog2(MAX_WINDOW+1)-1:0]       samples_used
);

	localparam int PW   = $clog2(MAX_WINDOW);
	localparam int CW   = $clog2(MAX_WINDOW + 1);
	localparam int CMW  = CW > twa_pkg::NOMINAL_W ? CW : twa_pkg::NOMINAL_W;
	localparam int SUMW = VALUE_WIDTH + PW;
	localparam int TXW  = TIME_WIDTH > twa_pkg::WINDOW_W ? TIME_WIDTH : twa_pkg::WINDOW_W;
	localparam int MW   = TIME_WIDTH + VALUE_WIDTH;

	localparam logic [PW-1:0] LAST_SLOT = PW'(MAX_WINDOW - 1);
	localparam logic [CW-1:0] DEPTH     = CW'(MAX_WINDOW);

	// ring slot n places back from s, wrapping at the ring depth (n <= depth)
	function automatic logic [PW-1:0] slot_back(input logic [PW-1:0] s, input logic [CW-1:0] n);
		logic [CW:0] a;
		logic [CW:0] b;
		logic [CW:0] r;
		a = (CW+1)'(s);
		b = (CW+1)'(n);
		if (a >= b)
			r = a - b;
		else
			r = a + (CW+1)'(MAX_WINDOW) - b;
		return r[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] slot_prev(input logic [PW-1:0] p);
		return (p == '0) ? LAST_SLOT : p - 1'b1;
	endfunction

	function automatic logic [PW-1:0] slot_next(input logic [PW-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	// configuration
	logic [twa_pkg::WINDOW_W-1:0]  window_q;
	logic [twa_pkg::NOMINAL_W-1:0] nominal_q;
	logic [twa_pkg::NOMINAL_W-1:0] minimum_q;

	// sequencer and block state
	twa_pkg::twa_state_t state_q, state_d;
	logic [PW-1:0]              wp_q;
	logic [CW-1:0]              stored_q;
	logic [CW-1:0]              fresh_q;
	logic [CW-1:0]              cnt_q;
	logic signed [SUMW-1:0]     sum_q;
	logic [MAX_WINDOW-1:0]      flag_q;
	logic signed [VALUE_WIDTH-1:0] held_q;
	logic                       pub_q;

	// walk pointer and read stage
	logic [PW-1:0]              ptr_q;
	logic [CW-1:0]              rem_q;
	logic                       valid_s1;
	logic [PW-1:0]              slot_s1;

	// request payload
	logic [TIME_WIDTH-1:0]         t_q;
	logic [VALUE_WIDTH-1:0]        v_q;
	logic [PW-1:0]                 s_q;
	logic [TIME_WIDTH-1:0]         start_q;

	// output register
	logic                          result_valid_q;
	logic                          ready_res_q;
	logic signed [VALUE_WIDTH-1:0] average_q;
	logic [CW-1:0]                 samples_used_q;

	// ring memory, entries hold {time, value}
	logic [MW-1:0] ring_mem [MAX_WINDOW];
	logic [MW-1:0] rd_q;
	logic          mem_we;
	logic          mem_re;
	logic [PW-1:0] mem_raddr;

	logic [TIME_WIDTH-1:0]         rd_time;
	logic signed [VALUE_WIDTH-1:0] rd_value;
	logic signed [SUMW-1:0]        rd_ext;

	logic                  take;
	logic [CMW-1:0]        nom_ext;
	logic [CW-1:0]         nom_c;
	logic [CW-1:0]         stored_n;
	logic [CW-1:0]         fresh_n;
	logic                  go_walk;
	logic [TXW-1:0]        t_ext;
	logic [TXW-1:0]        w_ext;
	logic [TXW-1:0]        start_c;
	logic                  s1_flag;
	logic                  rd_old;
	logic                  walking;
	logic                  brk;
	logic                  issue;
	logic                  phase_end;
	logic                  drop_new;
	logic                  drop_s1;
	logic                  admit_s1;
	logic                  publish;
	logic                  div_start;
	logic                  div_done;
	logic signed [SUMW-1:0] div_quot;
	logic                  out_load;

	assign take = sample_valid && sample_ready;

	// nominal count of zero acts as one, values past the ring depth act as the depth
	always_comb begin
		nom_ext = CMW'(nominal_q);
		if (nominal_q == '0)
			nom_c = CW'(1);
		else if (nom_ext > CMW'(MAX_WINDOW))
			nom_c = DEPTH;
		else
			nom_c = nom_ext[CW-1:0];
	end

	// window start, clamped at zero
	assign t_ext   = TXW'(sample_time);
	assign w_ext   = TXW'(window_q);
	assign start_c = (t_ext > w_ext) ? t_ext - w_ext : '0;

	assign stored_n = (stored_q < DEPTH) ? stored_q + 1'b1 : stored_q;
	assign fresh_n  = (fresh_q < DEPTH) ? fresh_q + 1'b1 : fresh_q;
	assign go_walk  = stored_n >= nom_c;

	assign rd_time  = rd_q[MW-1 -: TIME_WIDTH];
	assign rd_value = $signed(rd_q[VALUE_WIDTH-1:0]);
	assign rd_ext   = SUMW'(rd_value);

	assign s1_flag  = flag_q[slot_s1];
	assign rd_old   = rd_time < start_q;
	assign walking  = (state_q == twa_pkg::ST_EVICT_CNT) || (state_q == twa_pkg::ST_EVICT_AGE)
		|| (state_q == twa_pkg::ST_ADMIT);

	// the age walk stops at the first sample in the average that is still inside the window
	assign brk       = (state_q == twa_pkg::ST_EVICT_AGE) && valid_s1 && s1_flag && !rd_old;
	assign issue     = walking && (rem_q != '0) && !brk;
	assign phase_end = walking && (((rem_q == '0) && !valid_s1) || brk);

	assign drop_new = (state_q == twa_pkg::ST_LOAD) && flag_q[s_q];
	assign drop_s1  = valid_s1 && s1_flag && ((state_q == twa_pkg::ST_EVICT_CNT)
		|| ((state_q == twa_pkg::ST_EVICT_AGE) && rd_old));
	assign admit_s1 = valid_s1 && (state_q == twa_pkg::ST_ADMIT) && !s1_flag && !rd_old;

	assign publish = (cnt_q != '0) && (CMW'(cnt_q) >= CMW'(minimum_q));

	assign mem_we    = state_q == twa_pkg::ST_LOAD;
	assign mem_re    = take || issue;
	assign mem_raddr = take ? wp_q : ptr_q;

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			twa_pkg::ST_IDLE: begin
				if (take)
					state_d = twa_pkg::ST_LOAD;
			end
			twa_pkg::ST_LOAD: begin
				state_d = go_walk ? twa_pkg::ST_EVICT_CNT : twa_pkg::ST_DONE;
			end
			twa_pkg::ST_EVICT_CNT: begin
				if (phase_end)
					state_d = twa_pkg::ST_EVICT_AGE;
			end
			twa_pkg::ST_EVICT_AGE: begin
				if (phase_end)
					state_d = twa_pkg::ST_ADMIT;
			end
			twa_pkg::ST_ADMIT: begin
				if (phase_end) begin
					if (publish) begin
						div_start = 1'b1;
						state_d   = twa_pkg::ST_DIV;
					end else begin
						state_d = twa_pkg::ST_DONE;
					end
				end
			end
			twa_pkg::ST_DIV: begin
				if (div_done)
					state_d = twa_pkg::ST_DONE;
			end
			twa_pkg::ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					out_load = 1'b1;
					state_d  = twa_pkg::ST_IDLE;
				end
			end
			default: state_d = twa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= twa_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= '0;
			nominal_q <= twa_pkg::NOMINAL_RESET;
			minimum_q <= twa_pkg::MINIMUM_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				twa_pkg::CFG_WINDOW_DURATION: window_q  <= cfg_data[twa_pkg::WINDOW_W-1:0];
				twa_pkg::CFG_NOMINAL_COUNT:   nominal_q <= cfg_data[twa_pkg::NOMINAL_W-1:0];
				twa_pkg::CFG_MINIMUM_COUNT:   minimum_q <= cfg_data[twa_pkg::NOMINAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			stored_q <= '0;
			fresh_q  <= '0;
			cnt_q    <= '0;
			sum_q    <= '0;
			flag_q   <= '0;
			held_q   <= '0;
			pub_q    <= 1'b0;
			ptr_q    <= '0;
			rem_q    <= '0;
			valid_s1 <= 1'b0;
			slot_s1  <= '0;
		end else begin
			// one sum update a cycle: overwrite drop, walk drop or admit
			if (drop_new || drop_s1) begin
				sum_q <= sum_q - rd_ext;
				cnt_q <= cnt_q - 1'b1;
			end else if (admit_s1) begin
				sum_q <= sum_q + rd_ext;
				cnt_q <= cnt_q + 1'b1;
			end
			if (drop_s1)
				flag_q[slot_s1] <= 1'b0;
			if (admit_s1)
				flag_q[slot_s1] <= 1'b1;

			valid_s1 <= issue;
			if (issue) begin
				slot_s1 <= ptr_q;
				ptr_q   <= (state_q == twa_pkg::ST_EVICT_AGE) ? slot_next(ptr_q) : slot_prev(ptr_q);
				rem_q   <= rem_q - 1'b1;
			end

			if (state_q == twa_pkg::ST_LOAD) begin
				flag_q[s_q] <= 1'b0;
				wp_q        <= slot_next(s_q);
				stored_q    <= stored_n;
				fresh_q     <= fresh_n;
				pub_q       <= 1'b0;
				// entries past the nominal count, oldest-ward from age nominal
				ptr_q       <= slot_back(s_q, nom_c);
				rem_q       <= stored_n - nom_c;
			end

			if (phase_end) begin
				unique case (state_q)
					twa_pkg::ST_EVICT_CNT: begin
						// aged tail: from the oldest considered sample toward the newest
						ptr_q <= slot_back(s_q, nom_c - 1'b1);
						rem_q <= (nom_c > fresh_q) ? nom_c - fresh_q : '0;
					end
					twa_pkg::ST_EVICT_AGE: begin
						ptr_q <= s_q;
						rem_q <= (fresh_q < nom_c) ? fresh_q : nom_c;
					end
					default: fresh_q <= '0;
				endcase
			end

			if (div_done) begin
				held_q <= div_quot[VALUE_WIDTH-1:0];
				pub_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			t_q     <= sample_time;
			v_q     <= sample_value;
			s_q     <= wp_q;
			start_q <= start_c[TIME_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			ring_mem[s_q] <= {t_q, v_q};
		if (mem_re)
			rd_q <= ring_mem[mem_raddr];
	end

	twa_div #(
		.NUM_W(SUMW),
		.DEN_W(CW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (sum_q),
		.den   (cnt_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			ready_res_q    <= 1'b0;
			average_q      <= '0;
			samples_used_q <= '0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
			ready_res_q    <= pub_q;
			average_q      <= held_q;
			samples_used_q <= cnt_q;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign sample_ready = state_q == twa_pkg::ST_IDLE;
	assign result_valid = result_valid_q;
	assign ready_res    = ready_res_q;
	assign average      = average_q;
	assign samples_used = samples_used_q;

endmodule

/* hdl/twa_chk.sv */
// twa_chk: port-level checks for the time and count window average block
// depends on the top level's port list; bound to it at the end of this file

module twa_chk #(
	parameter int MAX_WINDOW  = 64,
	parameter int VALUE_WIDTH = 32
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              sample_valid,
	input logic                              sample_ready,
	input logic                              result_valid,
	input logic                              result_ready,
	input logic                              ready_res,
	input logic signed [VALUE_WIDTH-1:0]     average,
	input logic [$clog2(MAX_WINDOW+1)-1:0]   samples_used
);

	localparam int CW = $clog2(MAX_WINDOW + 1);

	logic signed [VALUE_WIDTH-1:0] last_avg_q;

	// average carried by the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_avg_q <= '0;
		else if (result_valid && result_ready)
			last_avg_q <= average;
	end

	// a taken request drops sample_ready while it is in work, before the next is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("request taken while the previous one is in work");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(average)
			&& $stable(ready_res) && $stable(samples_used))
		else $error("stalled result changed");

	a_held_average: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !ready_res |-> average == last_avg_q)
		else $error("average not held when no new average was computed");

	a_publish_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ready_res |-> samples_used != '0)
		else $error("average published over an empty window");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> samples_used <= CW'(MAX_WINDOW))
		else $error("samples used exceeds the ring depth");

endmodule

bind time_and_count_window_average twa_chk #(
	.MAX_WINDOW (MAX_WINDOW),
	.VALUE_WIDTH(VALUE_WIDTH)
) u_twa_chk (.*);
